[rtl/fuzzy_max_aggregate_cog_defuzzifier_unit_defines.svh]
// assertion macros for the fuzzy output stage
`ifndef FUZZY_MAX_AGGREGATE_COG_DEFUZZIFIER_UNIT_DEFINES_SVH
`define FUZZY_MAX_AGGREGATE_COG_DEFUZZIFIER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FMACD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmacd check failed");
`define FMACD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmacd check failed");
`else
`define FMACD_ASSERT_SAME(label, ante, cons)
`define FMACD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/fmacd_pkg.sv]
`default_nettype none
package fmacd_pkg;

    localparam int LIN_TERMS = 4;
    localparam int ROT_TERMS = 3;

    localparam int DEG_W  = 13;
    localparam int FRAC_W = 12;
    localparam logic [DEG_W-1:0] ONE_Q12 = DEG_W'(4096);

    localparam int MAX_TERMS = (LIN_TERMS > ROT_TERMS) ? LIN_TERMS : ROT_TERMS;
    localparam int CNT_W     = $clog2(MAX_TERMS);
    localparam int SUM_W     = $clog2(MAX_TERMS * 4096 + 1);
    localparam int WSUM_W    = $clog2(4096 * MAX_TERMS * (MAX_TERMS - 1) / 2 + 1);
    localparam int DEN_W     = $clog2(MAX_TERMS * 4096 * (MAX_TERMS - 1) + 1);
    localparam int DIV_CNT_W = $clog2(DEG_W);

    localparam logic [CNT_W-1:0] LIN_LAST = CNT_W'(LIN_TERMS - 1);
    localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(ROT_TERMS - 1);
    localparam logic [DEN_W-1:0] LIN_SCALE = DEN_W'(LIN_TERMS - 1);
    localparam logic [DEN_W-1:0] ROT_SCALE = DEN_W'(ROT_TERMS - 1);

    localparam logic SET_LIN = 1'b0;
    localparam logic SET_ROT = 1'b1;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic             target_set;
        logic [1:0]       term_index;
        logic             last_rule;
    } rule_item_t;

    typedef struct packed {
        logic [DEG_W-1:0] linear_speed;
        logic [DEG_W-1:0] rotation_speed;
        logic             linear_empty;
        logic             rotation_empty;
    } result_item_t;

    typedef struct packed {
        logic             raise;
        logic             clear;
        logic             wr_set;
        logic [1:0]       wr_idx;
        logic [DEG_W-1:0] wr_degree;
        logic             rd_set;
        logic [CNT_W-1:0] rd_idx;
    } store_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SWEEP = 5'b00010,
        ST_SCALE = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage
`default_nettype wire

[rtl/fmacd_term_store.sv]
`default_nettype none
module fmacd_term_store (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fmacd_pkg::store_ctrl_t      ctrl,
    output logic [fmacd_pkg::DEG_W-1:0]      rd_data
);

    logic [fmacd_pkg::DEG_W-1:0] lin_terms_reg [fmacd_pkg::LIN_TERMS];
    logic [fmacd_pkg::DEG_W-1:0] rot_terms_reg [fmacd_pkg::ROT_TERMS];
    logic [fmacd_pkg::DEG_W-1:0] deg_sat;

    // degrees above one saturate
    assign deg_sat = (ctrl.wr_degree > fmacd_pkg::ONE_Q12) ? fmacd_pkg::ONE_Q12
                                                           : ctrl.wr_degree;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < fmacd_pkg::LIN_TERMS; j++)
            begin
                lin_terms_reg[j] <= '0;
            end
            for (int j = 0; j < fmacd_pkg::ROT_TERMS; j++)
            begin
                rot_terms_reg[j] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int j = 0; j < fmacd_pkg::LIN_TERMS; j++)
            begin
                lin_terms_reg[j] <= '0;
            end
            for (int j = 0; j < fmacd_pkg::ROT_TERMS; j++)
            begin
                rot_terms_reg[j] <= '0;
            end
        end
        else if (ctrl.raise)
        begin
            // max aggregation, out of range index matches no entry
            for (int j = 0; j < fmacd_pkg::LIN_TERMS; j++)
            begin
                if (ctrl.wr_set == fmacd_pkg::SET_LIN && 32'(ctrl.wr_idx) == j
                    && deg_sat > lin_terms_reg[j])
                begin
                    lin_terms_reg[j] <= deg_sat;
                end
            end
            for (int j = 0; j < fmacd_pkg::ROT_TERMS; j++)
            begin
                if (ctrl.wr_set == fmacd_pkg::SET_ROT && 32'(ctrl.wr_idx) == j
                    && deg_sat > rot_terms_reg[j])
                begin
                    rot_terms_reg[j] <= deg_sat;
                end
            end
        end
    end

    always_comb
    begin
        rd_data = '0;
        for (int j = 0; j < fmacd_pkg::LIN_TERMS; j++)
        begin
            if (ctrl.rd_set == fmacd_pkg::SET_LIN
                && ctrl.rd_idx == fmacd_pkg::CNT_W'(j))
            begin
                rd_data = lin_terms_reg[j];
            end
        end
        for (int j = 0; j < fmacd_pkg::ROT_TERMS; j++)
        begin
            if (ctrl.rd_set == fmacd_pkg::SET_ROT
                && ctrl.rd_idx == fmacd_pkg::CNT_W'(j))
            begin
                rd_data = rot_terms_reg[j];
            end
        end
    end

endmodule
`default_nettype wire

[rtl/fmacd_serial_div.sv]
`default_nettype none
module fmacd_serial_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [fmacd_pkg::WSUM_W-1:0] numer,
    input  wire logic [fmacd_pkg::DEN_W-1:0]  denom,
    output logic                              done,
    output logic [fmacd_pkg::DEG_W-1:0]       quot
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [fmacd_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [fmacd_pkg::DEN_W-1:0]       rem_reg;
    logic [fmacd_pkg::DEN_W-1:0]       den_reg;
    logic [fmacd_pkg::DEG_W-1:0]       nbits_reg;
    logic [fmacd_pkg::DEG_W-1:0]       quot_reg;
    logic [fmacd_pkg::DEN_W:0]         shifted;
    logic [fmacd_pkg::DEN_W+1:0]       diff;
    logic                              neg;

    // one quotient bit per cycle, numerator is numer times 4096
    assign shifted = {rem_reg, nbits_reg[fmacd_pkg::DEG_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign neg     = diff[fmacd_pkg::DEN_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && cnt_reg == '0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= fmacd_pkg::DIV_CNT_W'(fmacd_pkg::DEG_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // numerator high part, always below the divisor
            rem_reg   <= {{(fmacd_pkg::DEN_W - fmacd_pkg::WSUM_W + 1){1'b0}},
                          numer[fmacd_pkg::WSUM_W-1:1]};
            den_reg   <= denom;
            nbits_reg <= {numer[0], {fmacd_pkg::FRAC_W{1'b0}}};
            quot_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg   <= neg ? shifted[fmacd_pkg::DEN_W-1:0] : diff[fmacd_pkg::DEN_W-1:0];
            nbits_reg <= {nbits_reg[fmacd_pkg::DEG_W-2:0], 1'b0};
            quot_reg  <= {quot_reg[fmacd_pkg::DEG_W-2:0], !neg};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

[rtl/fuzzy_max_aggregate_cog_defuzzifier_unit.sv]
// non-last rule item: taken while idle, next item may follow in the next cycle
// last rule item: result set by the term sweep and the 13-step bit-serial centroid divider
// shared by both sets
// an empty set skips its divide; no item is taken until the result enters the output register
// reset clears both term sets, the sequencer and the output valid at once
`default_nettype none
`include "fuzzy_max_aggregate_cog_defuzzifier_unit_defines.svh"
module fuzzy_max_aggregate_cog_defuzzifier_unit (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    rule_valid,
    output logic                         rule_stall,
    input  wire fmacd_pkg::rule_item_t   rule_item,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output fmacd_pkg::result_item_t      result_item
);

    fmacd_pkg::state_t                state_reg;
    logic                             set_reg;
    logic [fmacd_pkg::CNT_W-1:0]      idx_reg;
    logic [fmacd_pkg::SUM_W-1:0]      tail_reg;
    logic [fmacd_pkg::WSUM_W-1:0]     wsum_reg;
    logic [fmacd_pkg::DEG_W-1:0]      lin_speed_reg;
    logic [fmacd_pkg::DEG_W-1:0]      rot_speed_reg;
    logic                             lin_empty_reg;
    logic                             rot_empty_reg;
    logic                             out_valid_reg;
    fmacd_pkg::result_item_t          out_item_reg;

    fmacd_pkg::store_ctrl_t           store_ctrl;
    logic [fmacd_pkg::DEG_W-1:0]      rd_data;
    logic [fmacd_pkg::SUM_W-1:0]      tail_sum;
    logic [fmacd_pkg::DEN_W-1:0]      den;
    logic                             div_start;
    logic                             div_done;
    logic [fmacd_pkg::DEG_W-1:0]      div_quot;
    logic                             rule_take;
    logic                             out_free;
    logic                             set_finish;

    assign rule_stall = state_reg != fmacd_pkg::ST_IDLE;
    assign rule_take  = rule_valid && !rule_stall;
    assign out_free   = !out_valid_reg || !result_stall;

    assign store_ctrl.raise     = rule_take;
    assign store_ctrl.clear     = state_reg == fmacd_pkg::ST_DONE;
    assign store_ctrl.wr_set    = rule_item.target_set;
    assign store_ctrl.wr_idx    = rule_item.term_index;
    assign store_ctrl.wr_degree = rule_item.degree;
    assign store_ctrl.rd_set    = set_reg;
    assign store_ctrl.rd_idx    = idx_reg;

    fmacd_term_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (store_ctrl),
        .rd_data (rd_data)
    );

    // running tail sum, sum of tails above index zero gives the weighted sum
    assign tail_sum = tail_reg + fmacd_pkg::SUM_W'(rd_data);
    assign den = fmacd_pkg::DEN_W'(tail_reg)
               * ((set_reg == fmacd_pkg::SET_ROT) ? fmacd_pkg::ROT_SCALE
                                                  : fmacd_pkg::LIN_SCALE);
    assign div_start = state_reg == fmacd_pkg::ST_SCALE && tail_reg != '0;

    fmacd_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (wsum_reg),
        .denom (den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign set_finish = (state_reg == fmacd_pkg::ST_SCALE && tail_reg == '0)
                     || (state_reg == fmacd_pkg::ST_DIV && div_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmacd_pkg::ST_IDLE;
            set_reg       <= fmacd_pkg::SET_LIN;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall && state_reg != fmacd_pkg::ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                fmacd_pkg::ST_IDLE:
                begin
                    if (rule_take && rule_item.last_rule)
                    begin
                        set_reg   <= fmacd_pkg::SET_LIN;
                        idx_reg   <= fmacd_pkg::LIN_LAST;
                        state_reg <= fmacd_pkg::ST_SWEEP;
                    end
                end
                fmacd_pkg::ST_SWEEP:
                begin
                    if (idx_reg == '0)
                    begin
                        state_reg <= fmacd_pkg::ST_SCALE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                fmacd_pkg::ST_SCALE:
                begin
                    if (tail_reg != '0)
                    begin
                        state_reg <= fmacd_pkg::ST_DIV;
                    end
                    else if (set_reg == fmacd_pkg::SET_LIN)
                    begin
                        set_reg   <= fmacd_pkg::SET_ROT;
                        idx_reg   <= fmacd_pkg::ROT_LAST;
                        state_reg <= fmacd_pkg::ST_SWEEP;
                    end
                    else
                    begin
                        state_reg <= fmacd_pkg::ST_DONE;
                    end
                end
                fmacd_pkg::ST_DIV:
                begin
                    if (div_done)
                    begin
                        if (set_reg == fmacd_pkg::SET_LIN)
                        begin
                            set_reg   <= fmacd_pkg::SET_ROT;
                            idx_reg   <= fmacd_pkg::ROT_LAST;
                            state_reg <= fmacd_pkg::ST_SWEEP;
                        end
                        else
                        begin
                            state_reg <= fmacd_pkg::ST_DONE;
                        end
                    end
                end
                fmacd_pkg::ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= fmacd_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= fmacd_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == fmacd_pkg::ST_IDLE)
        begin
            tail_reg <= '0;
            wsum_reg <= '0;
        end
        else if (state_reg == fmacd_pkg::ST_SWEEP)
        begin
            tail_reg <= tail_sum;
            if (idx_reg != '0)
            begin
                wsum_reg <= wsum_reg + fmacd_pkg::WSUM_W'(tail_sum);
            end
        end
        else if (set_finish && set_reg == fmacd_pkg::SET_LIN)
        begin
            tail_reg <= '0;
            wsum_reg <= '0;
        end

        if (set_finish)
        begin
            if (set_reg == fmacd_pkg::SET_LIN)
            begin
                lin_speed_reg <= (tail_reg == '0) ? '0 : div_quot;
                lin_empty_reg <= tail_reg == '0;
            end
            else
            begin
                rot_speed_reg <= (tail_reg == '0) ? '0 : div_quot;
                rot_empty_reg <= tail_reg == '0;
            end
        end

        if (state_reg == fmacd_pkg::ST_DONE && out_free)
        begin
            out_item_reg.linear_speed   <= lin_speed_reg;
            out_item_reg.rotation_speed <= rot_speed_reg;
            out_item_reg.linear_empty   <= lin_empty_reg;
            out_item_reg.rotation_empty <= rot_empty_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    `FMACD_ASSERT_NEXT(a_last_starts_sweep, rule_take && rule_item.last_rule,
        state_reg == fmacd_pkg::ST_SWEEP && set_reg == fmacd_pkg::SET_LIN)
    `FMACD_ASSERT_NEXT(a_done_loads_output, state_reg == fmacd_pkg::ST_DONE && out_free,
        result_valid && state_reg == fmacd_pkg::ST_IDLE)
    `FMACD_ASSERT_SAME(a_empty_means_zero, result_valid,
        (!result_item.linear_empty || result_item.linear_speed == '0)
        && (!result_item.rotation_empty || result_item.rotation_speed == '0))
    `FMACD_ASSERT_SAME(a_speed_in_range, result_valid,
        result_item.linear_speed <= fmacd_pkg::ONE_Q12
        && result_item.rotation_speed <= fmacd_pkg::ONE_Q12)

endmodule
`default_nettype wire
